// ----- rtl/dfcp_pkg.sv -----
// Shared types and constants of the display frame component parser.
package dfcp_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = 2;
   localparam int RSP_DATA_WIDTH = 48;

   typedef enum logic [2:0] {
      PH_H0   = 3'd0,
      PH_H1   = 3'd1,
      PH_H2   = 3'd2,
      PH_H3   = 3'd3,
      PH_CCMD = 3'd4,
      PH_CCNT = 3'd5,
      PH_SKIP = 3'd6,
      PH_DONE = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_OVER  = 2'd2,
      ST_TRUNC = 2'd3
   } status_type;

   typedef enum logic {
      KIND_COMPONENT = 1'b0,
      KIND_SUMMARY   = 1'b1
   } kind_type;

   // Everything one input byte causes: an optional component record and an
   // optional end-of-frame summary.
   typedef struct packed {
      logic       has_comp;
      logic [2:0] comp_index;
      logic [7:0] comp_command;
      logic [7:0] comp_count;
      logic       has_summary;
      logic [15:0] sum_command;
      logic [7:0] sum_length;
      logic [3:0] sum_total;
      status_type sum_status;
   } event_type;

endpackage

// ----- rtl/dfcp_front.sv -----
// Front end: tracks the frame layout byte by byte and builds result events.
module dfcp_front #(
   parameter int MAX_COMPONENTS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          frame_byte,
   input  logic                frame_end,
   output logic                push,
   output dfcp_pkg::event_type push_event
);

   localparam logic [3:0] MAX_SLOTS = 4'(MAX_COMPONENTS);

   dfcp_pkg::phase_type  phase_ff, phase_in, phase_step;
   dfcp_pkg::status_type status_ff, status_in, status_step;
   logic [8:0]  skip_ff, skip_in, skip_step, skip_dec;
   logic [3:0]  slot_ff, slot_in, slot_step;
   logic [15:0] cmd_ff, cmd_in, cmd_step;
   logic [7:0]  len_ff, len_in, len_step;
   logic [7:0]  pend_ff, pend_in, pend_step;
   logic [3:0]  total_ff, total_in, total_step;
   logic        open_ff, open_in, open_step;

   assign skip_dec = (skip_ff != 9'd0) ? skip_ff - 9'd1 : skip_ff;

   // Next phase of the parse.
   always_comb begin
      phase_step = phase_ff;
      case (phase_ff)
         dfcp_pkg::PH_H0:   phase_step = dfcp_pkg::PH_H1;
         dfcp_pkg::PH_H1:   phase_step = dfcp_pkg::PH_H2;
         dfcp_pkg::PH_H2:   phase_step = dfcp_pkg::PH_H3;
         dfcp_pkg::PH_H3:   phase_step = dfcp_pkg::PH_CCMD;
         dfcp_pkg::PH_CCMD: phase_step = dfcp_pkg::PH_CCNT;
         dfcp_pkg::PH_CCNT: begin
            if (frame_byte > len_ff) begin
               phase_step = dfcp_pkg::PH_DONE;
            end else if (slot_step >= MAX_SLOTS) begin
               phase_step = dfcp_pkg::PH_DONE;
            end else if (frame_byte == 8'd0) begin
               phase_step = dfcp_pkg::PH_CCMD;
            end else begin
               phase_step = dfcp_pkg::PH_SKIP;
            end
         end
         dfcp_pkg::PH_SKIP: begin
            if (skip_dec == 9'd0) begin
               phase_step = dfcp_pkg::PH_CCMD;
            end
         end
         default: phase_step = phase_ff;
      endcase
   end

   // Datapath updates of the per-frame registers.
   always_comb begin
      status_step = status_ff;
      skip_step   = skip_ff;
      slot_step   = slot_ff;
      cmd_step    = cmd_ff;
      len_step    = len_ff;
      pend_step   = pend_ff;
      total_step  = total_ff;
      open_step   = open_ff;
      case (phase_ff)
         dfcp_pkg::PH_H0: cmd_step = {8'd0, frame_byte};
         dfcp_pkg::PH_H1: cmd_step = {frame_byte, cmd_ff[7:0]};
         dfcp_pkg::PH_H2: len_step = frame_byte;
         dfcp_pkg::PH_CCMD: begin
            pend_step = frame_byte;
            if (frame_end) begin
               status_step = dfcp_pkg::ST_TRUNC;
            end
         end
         dfcp_pkg::PH_CCNT: begin
            slot_step = slot_ff + 4'd1;
            if (frame_byte == 8'd0) begin
               open_step = 1'b0;
            end else if (open_ff) begin
               total_step = total_ff + 4'd1;
            end
            if (frame_byte > len_ff) begin
               status_step = dfcp_pkg::ST_OVER;
            end
            skip_step = {frame_byte, 1'b0};
         end
         dfcp_pkg::PH_SKIP: skip_step = skip_dec;
         default: skip_step = skip_ff;
      endcase
   end

   // Register next values; the last byte of a frame returns everything to reset.
   always_comb begin
      phase_in  = phase_ff;
      status_in = status_ff;
      skip_in   = skip_ff;
      slot_in   = slot_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      pend_in   = pend_ff;
      total_in  = total_ff;
      open_in   = open_ff;
      if (accept) begin
         if (frame_end) begin
            phase_in  = dfcp_pkg::PH_H0;
            status_in = dfcp_pkg::ST_OK;
            skip_in   = 9'd0;
            slot_in   = 4'd0;
            cmd_in    = 16'd0;
            len_in    = 8'd0;
            pend_in   = 8'd0;
            total_in  = 4'd0;
            open_in   = 1'b1;
         end else begin
            phase_in  = phase_step;
            status_in = status_step;
            skip_in   = skip_step;
            slot_in   = slot_step;
            cmd_in    = cmd_step;
            len_in    = len_step;
            pend_in   = pend_step;
            total_in  = total_step;
            open_in   = open_step;
         end
      end
   end

   // Event for the queue.
   always_comb begin
      push_event              = '0;
      push_event.has_comp     = (phase_ff == dfcp_pkg::PH_CCNT);
      push_event.comp_index   = slot_ff[2:0];
      push_event.comp_command = pend_ff;
      push_event.comp_count   = frame_byte;
      push_event.has_summary  = frame_end;
      if (phase_ff == dfcp_pkg::PH_H0 || phase_ff == dfcp_pkg::PH_H1 ||
          phase_ff == dfcp_pkg::PH_H2) begin
         push_event.sum_status = dfcp_pkg::ST_SHORT;
      end else begin
         push_event.sum_command = cmd_step;
         push_event.sum_length  = len_step;
         push_event.sum_total   = total_step;
         push_event.sum_status  = status_step;
      end
   end

   assign push = accept && (push_event.has_comp || push_event.has_summary);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= dfcp_pkg::PH_H0;
         status_ff <= dfcp_pkg::ST_OK;
         skip_ff   <= 9'd0;
         slot_ff   <= 4'd0;
         cmd_ff    <= 16'd0;
         len_ff    <= 8'd0;
         pend_ff   <= 8'd0;
         total_ff  <= 4'd0;
         open_ff   <= 1'b1;
      end else begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         skip_ff   <= skip_in;
         slot_ff   <= slot_in;
         cmd_ff    <= cmd_in;
         len_ff    <= len_in;
         pend_ff   <= pend_in;
         total_ff  <= total_in;
         open_ff   <= open_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= MAX_SLOTS)
      else $error("component slot went past the limit");
   a_skip_only_in_skip: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == dfcp_pkg::PH_SKIP) |-> (skip_ff != 9'd0))
      else $error("skip phase with nothing left to skip");
`endif

endmodule

// ----- rtl/dfcp_queue.sv -----
// Short event queue between the parsing front end and the result back end.
module dfcp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dfcp_pkg::event_type push_event,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output dfcp_pkg::event_type head
);

   localparam logic [dfcp_pkg::QUEUE_PTR_WIDTH:0] DEPTH_COUNT =
      (dfcp_pkg::QUEUE_PTR_WIDTH + 1)'(dfcp_pkg::QUEUE_DEPTH);
   localparam logic [dfcp_pkg::QUEUE_PTR_WIDTH-1:0] PTR_ONE =
      dfcp_pkg::QUEUE_PTR_WIDTH'(1);
   localparam logic [dfcp_pkg::QUEUE_PTR_WIDTH:0] COUNT_ONE =
      (dfcp_pkg::QUEUE_PTR_WIDTH + 1)'(1);

   dfcp_pkg::event_type entries_ff [dfcp_pkg::QUEUE_DEPTH];
   logic [dfcp_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dfcp_pkg::QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dfcp_pkg::QUEUE_PTR_WIDTH:0]   count_ff, count_in;

   assign full      = (count_ff == DEPTH_COUNT);
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_ONE : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_ONE : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("event queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("event queue underflow");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      count_ff == DEPTH_COUNT |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");
`endif

endmodule

// ----- rtl/dfcp_back.sv -----
// Back end: turns queued events into result transactions in an output register.
module dfcp_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   head_valid,
   input  dfcp_pkg::event_type                    head,
   output logic                                   pop,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [dfcp_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast
);

   logic        valid_ff, valid_in;
   logic        comp_sent_ff, comp_sent_in;
   logic        load;
   logic        send_comp;
   logic [dfcp_pkg::RSP_DATA_WIDTH-1:0] data_ff, data_in;
   logic        user_ff, user_in;
   logic        last_ff, last_in;

   assign load      = head_valid && (!valid_ff || rsp_tready);
   assign send_comp = head.has_comp && !comp_sent_ff;

   // A head with both a component and a summary stays in the queue until its summary is loaded too.
   always_comb begin
      pop          = 1'b0;
      comp_sent_in = comp_sent_ff;
      valid_in     = valid_ff && !rsp_tready;
      if (load) begin
         valid_in = 1'b1;
         if (send_comp && head.has_summary) begin
            comp_sent_in = 1'b1;
         end else begin
            pop          = 1'b1;
            comp_sent_in = 1'b0;
         end
      end
   end

   always_comb begin
      data_in = '0;
      user_in = dfcp_pkg::KIND_SUMMARY;
      last_in = 1'b1;
      if (send_comp) begin
         user_in       = dfcp_pkg::KIND_COMPONENT;
         last_in       = !head.has_summary;
         data_in[2:0]  = head.comp_index;
         data_in[18:3] = {8'd0, head.comp_command};
         data_in[26:19] = head.comp_count;
      end else begin
         data_in[18:3]  = head.sum_command;
         data_in[34:27] = head.sum_length;
         data_in[38:35] = head.sum_total;
         data_in[40:39] = head.sum_status;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         comp_sent_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         comp_sent_ff <= comp_sent_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

`ifndef NO_ASSERTIONS
   a_summary_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && user_ff == dfcp_pkg::KIND_SUMMARY) |-> last_ff)
      else $error("summary not marked as last result");
   a_split_only_for_pairs: assert property (@(posedge clock) disable iff (reset)
      comp_sent_ff |-> (head_valid && head.has_comp && head.has_summary))
      else $error("partly sent head lost its second result");
`endif

endmodule

// ----- rtl/display_frame_component_parser_unit.sv -----
// Display frame parser: takes one frame byte per cycle on req_ (tlast marks the
// last byte) and returns a component record when each component's count byte
// arrives plus a summary on the last byte of the frame. A byte is accepted every
// cycle while the four-entry event queue between the parser and the output
// register has room; the result port delivers one transaction per cycle while
// rsp_tready is high, so a byte that ends a frame on a count byte yields two
// results in turn. Each result is held in the output register until taken.
module display_frame_component_parser_unit #(
   parameter int MAX_COMPONENTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] component_index, [18:3] command_word, [26:19] char_count,
   // [34:27] header_length, [38:35] component_total, [40:39] parse_status,
   // [47:41] zero
   output logic [dfcp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic        rsp_tuser,   // result_kind
   output logic        rsp_tlast    // run_last
);

   logic                accept;
   logic                push;
   logic                pop;
   logic                full;
   logic                not_empty;
   dfcp_pkg::event_type push_event;
   dfcp_pkg::event_type head;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   dfcp_front #(
      .MAX_COMPONENTS(MAX_COMPONENTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .frame_byte (req_tdata),
      .frame_end  (req_tlast),
      .push       (push),
      .push_event (push_event)
   );

   dfcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .full       (full),
      .not_empty  (not_empty),
      .head       (head)
   );

   dfcp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- dv/tb_display_frame_component_parser_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the display frame component parser unit.
module tb_display_frame_component_parser_unit;

   localparam int MAX_COMPONENTS = 8;
   localparam int RANDOM_BYTES = 1050;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      dfcp_pkg::kind_type   kind;
      logic [2:0]           index;
      logic [15:0]          command;
      logic [7:0]           count;
      logic [7:0]           length;
      logic [3:0]           total;
      dfcp_pkg::status_type status;
      logic                 is_last;
      logic [6:0]           pad;
   } frame_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;    // [7:0] frame_byte
   logic req_tlast = 1'b0;           // frame_end
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // index, command, count, length, total, status
   logic [dfcp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic rsp_tuser;                  // result_kind
   logic rsp_tlast;                  // run_last

   // Parser state mirrored by the predictor.
   dfcp_pkg::phase_type  frame_phase;
   logic [8:0]           text_left;
   logic [3:0]           comp_slot;
   logic [15:0]          frame_cmd;
   logic [7:0]           header_len;
   logic [7:0]           comp_cmd;
   dfcp_pkg::status_type frame_stat;
   logic [3:0]           comp_total;
   logic                 total_open;

   frame_result_type pending_results[$];
   logic [7:0] frame_buf[$];

   logic quiet_mode = 1'b0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int bytes_sent = 0;
   int frames_sent = 0;
   int records_seen = 0;
   int summaries_seen = 0;
   int status_seen[4] = '{0, 0, 0, 0};

   display_frame_component_parser_unit #(
      .MAX_COMPONENTS(MAX_COMPONENTS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("display_frame_component_parser_unit regression: fail");
         $finish;
      end
   end

   function automatic string result_text(input frame_result_type r);
      return $sformatf("kind=%0d idx=%0d cmd=%h cnt=%0d len=%0d tot=%0d st=%0d last=%0d pad=%h",
                       r.kind, r.index, r.command, r.count, r.length, r.total, r.status,
                       r.is_last, r.pad);
   endfunction

   task automatic push_result(input dfcp_pkg::kind_type kind, input logic [2:0] index,
                              input logic [15:0] command, input logic [7:0] count,
                              input logic [7:0] length, input logic [3:0] total,
                              input dfcp_pkg::status_type status, input logic is_last);
      frame_result_type r;
      r.kind = kind;
      r.index = index;
      r.command = command;
      r.count = count;
      r.length = length;
      r.total = total;
      r.status = status;
      r.is_last = is_last;
      r.pad = 7'd0;
      pending_results.push_back(r);
   endtask

   task automatic clear_frame_state();
      frame_phase = dfcp_pkg::PH_H0;
      text_left = 9'd0;
      comp_slot = 4'd0;
      frame_cmd = 16'd0;
      header_len = 8'd0;
      comp_cmd = 8'd0;
      frame_stat = dfcp_pkg::ST_OK;
      comp_total = 4'd0;
      total_open = 1'b1;
   endtask

   // Advances the mirrored parser by one accepted byte and queues what it causes.
   task automatic parse_frame_byte(input logic [7:0] b, input logic is_last);
      dfcp_pkg::phase_type ph;
      ph = frame_phase;
      case (ph)
         dfcp_pkg::PH_H0: begin
            frame_cmd = {8'h00, b};
            frame_phase = dfcp_pkg::PH_H1;
         end
         dfcp_pkg::PH_H1: begin
            frame_cmd[15:8] = b;
            frame_phase = dfcp_pkg::PH_H2;
         end
         dfcp_pkg::PH_H2: begin
            header_len = b;
            frame_phase = dfcp_pkg::PH_H3;
         end
         dfcp_pkg::PH_H3: frame_phase = dfcp_pkg::PH_CCMD;
         dfcp_pkg::PH_CCMD: begin
            comp_cmd = b;
            frame_phase = dfcp_pkg::PH_CCNT;
            if (is_last) frame_stat = dfcp_pkg::ST_TRUNC;
         end
         dfcp_pkg::PH_CCNT: begin
            push_result(dfcp_pkg::KIND_COMPONENT, comp_slot[2:0], {8'h00, comp_cmd}, b,
                        8'd0, 4'd0, dfcp_pkg::ST_OK, !is_last);
            // The total freezes at the first component that declares no text.
            if (b == 8'd0) total_open = 1'b0;
            else if (total_open) comp_total = comp_total + 4'd1;
            comp_slot = comp_slot + 4'd1;
            if (b > header_len) begin
               frame_stat = dfcp_pkg::ST_OVER;
               frame_phase = dfcp_pkg::PH_DONE;
            end else if (comp_slot >= MAX_COMPONENTS) begin
               frame_phase = dfcp_pkg::PH_DONE;
            end else if (b == 8'd0) begin
               frame_phase = dfcp_pkg::PH_CCMD;
            end else begin
               text_left = {b, 1'b0};
               frame_phase = dfcp_pkg::PH_SKIP;
            end
         end
         dfcp_pkg::PH_SKIP: begin
            if (text_left != 9'd0) text_left = text_left - 9'd1;
            if (text_left == 9'd0) frame_phase = dfcp_pkg::PH_CCMD;
         end
         default: ;
      endcase
      if (is_last) begin
         if (ph <= dfcp_pkg::PH_H2)
            push_result(dfcp_pkg::KIND_SUMMARY, 3'd0, 16'd0, 8'd0, 8'd0, 4'd0,
                        dfcp_pkg::ST_SHORT, 1'b1);
         else
            push_result(dfcp_pkg::KIND_SUMMARY, 3'd0, frame_cmd, 8'd0, header_len,
                        comp_total, frame_stat, 1'b1);
         clear_frame_state();
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while (!quiet_mode && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_frame_byte(b, is_last);
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
      frames_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Frames that end on byte 0, 1 and 2, and one that ends on the ignored byte 3.
   task automatic test_short_frames();
      frame_buf = {8'h00};
      send_frame();
      frame_buf = {8'hFF, 8'hFF};
      send_frame();
      frame_buf = {8'hAA, 8'h55, 8'h07};
      send_frame();
      frame_buf = {8'h01, 8'h80, 8'hFF, 8'hFF};
      send_frame();
   endtask

   // Text skipping, a zero count that freezes the total, then a count above
   // the header length followed by a byte that must be ignored.
   task automatic test_component_stream();
      frame_buf = {8'h34, 8'h12, 8'h02, 8'h00,
                   8'hFF, 8'h01, 8'h00, 8'hFF,
                   8'h81, 8'h00,
                   8'h10, 8'h03,
                   8'h5A};
      send_frame();
   endtask

   // The frame ends on a component command byte.
   task automatic test_truncated_frame();
      frame_buf = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h42};
      send_frame();
   endtask

   task automatic build_random_frame();
      int pick;
      int hl;
      int cnt;
      frame_buf.delete();
      pick = $urandom_range(99);
      if (pick < 10) begin
         // Noise: arbitrary bytes of arbitrary short length.
         repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom_range(255)));
         return;
      end
      pick = $urandom_range(99);
      if (pick < 40) hl = $urandom_range(0, 3);
      else if (pick < 75) hl = $urandom_range(4, 30);
      else hl = $urandom_range(0, 255);
      frame_buf.push_back(8'($urandom_range(255)));
      frame_buf.push_back(8'($urandom_range(255)));
      frame_buf.push_back(8'(hl));
      frame_buf.push_back(8'($urandom_range(255)));
      repeat ($urandom_range(0, 10)) begin
         pick = $urandom_range(99);
         if (pick < 35) cnt = 0;
         else if (pick < 80) cnt = $urandom_range(1, 4);
         else cnt = $urandom_range(0, 255);
         frame_buf.push_back(8'($urandom_range(255)));
         frame_buf.push_back(8'(cnt));
         if (cnt <= hl)
            repeat (2 * cnt) frame_buf.push_back(8'($urandom_range(255)));
      end
      // Vary where the frame stops: on a command byte, inside text or a count,
      // after trailing bytes, or cleanly after the last component.
      pick = $urandom_range(99);
      if (pick < 15) begin
         frame_buf.push_back(8'($urandom_range(255)));
      end else if (pick < 35) begin
         repeat ($urandom_range(1, 3))
            if (frame_buf.size() > 1) void'(frame_buf.pop_back());
      end else if (pick < 45) begin
         repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic test_random_frames();
      logic paused;
      int start_bytes;
      paused = 1'b0;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < RANDOM_BYTES) begin
         quiet_mode = (bytes_sent - start_bytes >= 350) && (bytes_sent - start_bytes < 600);
         if (!paused && bytes_sent - start_bytes >= 700) begin
            paused = 1'b1;
            wait_drained();
         end
         build_random_frame();
         send_frame();
      end
      quiet_mode = 1'b0;
   endtask

   always @(posedge clock) begin
      frame_result_type seen;
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind = dfcp_pkg::kind_type'(rsp_tuser);
         seen.index = rsp_tdata[2:0];
         seen.command = rsp_tdata[18:3];
         seen.count = rsp_tdata[26:19];
         seen.length = rsp_tdata[34:27];
         seen.total = rsp_tdata[38:35];
         seen.status = dfcp_pkg::status_type'(rsp_tdata[40:39]);
         seen.is_last = rsp_tlast;
         seen.pad = rsp_tdata[47:41];
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transaction: %s", $time, result_text(seen));
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (seen.kind !== want.kind || seen.index !== want.index ||
                seen.command !== want.command || seen.count !== want.count ||
                seen.length !== want.length || seen.total !== want.total ||
                seen.status !== want.status || seen.is_last !== want.is_last ||
                seen.pad !== want.pad) begin
               $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                        result_text(want), result_text(seen));
               mismatch_count++;
            end
            if (want.kind == dfcp_pkg::KIND_SUMMARY) begin
               summaries_seen++;
               status_seen[want.status]++;
            end else begin
               records_seen++;
            end
         end
      end
      rsp_tready <= quiet_mode || ($urandom_range(99) >= 30);
   end

   initial begin
      clear_frame_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_frames();
      test_component_stream();
      test_truncated_frame();
      wait_drained();
      test_random_frames();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d frames in %0d bytes; checked %0d component records and %0d summaries.",
               frames_sent, bytes_sent, records_seen, summaries_seen);
      $display("Summary status mix: ok %0d, short %0d, count over length %0d, truncated %0d.",
               status_seen[dfcp_pkg::ST_OK], status_seen[dfcp_pkg::ST_SHORT],
               status_seen[dfcp_pkg::ST_OVER], status_seen[dfcp_pkg::ST_TRUNC]);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("display_frame_component_parser_unit regression: pass");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatch_count,
                  pending_results.size());
         $display("display_frame_component_parser_unit regression: fail");
      end
      $finish;
   end

endmodule
